// ===== src/tileable_value_noise_fbm_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tileable value noise unit
// Concurrent checks sampled on clk, switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TILEABLE_VALUE_NOISE_FBM_UNIT_DEFINES_SVH
`define TILEABLE_VALUE_NOISE_FBM_UNIT_DEFINES_SVH

// same-cycle implication
`define TVN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tvn check failed");

// next-cycle implication
`define TVN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tvn check failed");

`endif

// ===== src/tvn_pkg.sv =====
// ----------------------------------------------------------------------------
// tvn_pkg
// Shared widths, constants, register codes and pipeline control type.
// ----------------------------------------------------------------------------
package tvn_pkg;

	localparam int FRAC       = 16;          // fraction bits of internal values
	localparam int COORD_W    = 16;
	localparam int OUT_W      = 16;
	localparam int BASE_W     = 7;
	localparam int MAX_BASE   = 64;
	localparam int UB_W       = 22;          // coord * period, period <= 64
	localparam int OCT_W      = 4;
	localparam int PERS_W     = 17;
	localparam int SEED_W     = 32;
	localparam int AMP_W      = 17;
	localparam int VAL_W      = 17;          // Q.16 values in 0..1.0 inclusive
	localparam int HALF       = 1 << (FRAC - 1);

	localparam logic [VAL_W-1:0] VAL_ONE = 17'h10000;

	localparam logic [31:0] HASH_X    = 32'd374761393;
	localparam logic [31:0] HASH_Y    = 32'd668265263;
	localparam logic [31:0] SEED_MUL  = 32'd362437;
	localparam logic [31:0] HASH_M    = 32'd1274126177;
	localparam logic [31:0] SEED_STEP = 32'd7919;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 2'd3;

	typedef struct packed {
		logic en;   // whole pipe advances
		logic vld;  // beat entering this unit
	} ctl_t;

endpackage

// ===== src/tvn_coef.sv =====
// ----------------------------------------------------------------------------
// tvn_coef
// Octave amplitudes, amplitude total, active mask and seed hash terms,
// all derived from the configuration registers.
// ----------------------------------------------------------------------------
module tvn_coef #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic clk,
	input  logic [tvn_pkg::OCT_W-1:0]  octaves,
	input  logic [tvn_pkg::PERS_W-1:0] persistence,
	input  logic [tvn_pkg::SEED_W-1:0] seed,
	output logic [MAX_OCTAVES-1:0][tvn_pkg::AMP_W-1:0]  amp,
	output logic [MAX_OCTAVES-1:0]                      act,
	output logic [tvn_pkg::AMP_W+$clog2(MAX_OCTAVES)-1:0] norm,
	output logic [MAX_OCTAVES-1:0][tvn_pkg::SEED_W-1:0] seed_term
);
	import tvn_pkg::*;

	localparam int NORM_W = AMP_W + $clog2(MAX_OCTAVES);

	logic [PERS_W-1:0] pers_eff;
	logic [4:0]        oct_eff;
	logic [MAX_OCTAVES-1:0][AMP_W-1:0] amp_q;
	logic [NORM_W-1:0] norm_q;
	logic [NORM_W-1:0] norm_sum;
	logic [MAX_OCTAVES-1:0][SEED_W-1:0] seed_q;

	always_comb begin
		pers_eff = (persistence > PERS_W'(VAL_ONE)) ? PERS_W'(VAL_ONE) : persistence;
		if (octaves == '0) begin
			oct_eff = 5'd1;
		end else if (5'(octaves) > 5'(MAX_OCTAVES)) begin
			oct_eff = 5'(MAX_OCTAVES);
		end else begin
			oct_eff = 5'(octaves);
		end
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			act[i] = 5'(i) < oct_eff;
		end
		norm_sum = '0;
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			if (act[i]) begin
				norm_sum = norm_sum + NORM_W'(amp_q[i]);
			end
		end
	end

	// amplitude chain settles one octave per cycle
	always_ff @(posedge clk) begin
		amp_q[0] <= VAL_ONE;
		for (int i = 1; i < MAX_OCTAVES; i++) begin
			amp_q[i] <= AMP_W'((34'(amp_q[i-1]) * 34'(pers_eff) + 34'(HALF)) >> 16);
		end
		norm_q <= norm_sum;
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			seed_q[i] <= (seed + 32'(i) * SEED_STEP) * SEED_MUL;
		end
	end

	assign amp       = amp_q;
	assign norm      = norm_q;
	assign seed_term = seed_q;

endmodule

// ===== src/tvn_octave.sv =====
// ----------------------------------------------------------------------------
// tvn_octave
// One octave lane: lattice cells, corner hashes, quintic fade and bilinear
// blend, seven register stages.
// ----------------------------------------------------------------------------
module tvn_octave #(
	parameter int OCT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  tvn_pkg::ctl_t ctl,
	input  logic [tvn_pkg::UB_W-1:0]   ub,
	input  logic [tvn_pkg::UB_W-1:0]   vb,
	input  logic [tvn_pkg::BASE_W-1:0] base,
	input  logic [tvn_pkg::SEED_W-1:0] seed_term,
	output logic [tvn_pkg::VAL_W-1:0]  n,
	output logic                       vld
);
	import tvn_pkg::*;

	localparam int PU_W   = UB_W + OCT;
	localparam int CELL_W = PU_W - FRAC;
	localparam int PER_W  = BASE_W + OCT;
	localparam int R_W    = 20;

	function automatic logic [R_W-1:0] fade_head(input logic [31:0] tt, input logic [FRAC-1:0] t);
		logic [36:0] q;
		q = 37'(tt) * 37'd6 + (37'd10 << 32) - ((37'(t) * 37'd15) << 16);
		return R_W'((q + 37'(HALF)) >> FRAC);
	endfunction

	function automatic logic [R_W-1:0] mul_rnd(input logic [FRAC-1:0] t, input logic [R_W-1:0] r);
		logic [FRAC+R_W-1:0] p;
		p = (FRAC+R_W)'(t) * (FRAC+R_W)'(r) + (FRAC+R_W)'(HALF);
		return R_W'(p >> FRAC);
	endfunction

	// 24-bit hash fraction scaled to 0..1.0, divide by 2^24-1 done as
	// shift plus one correction step
	function automatic logic [VAL_W-1:0] corner(input logic [31:0] g);
		logic [31:0] h;
		logic [40:0] x;
		logic [16:0] q0;
		logic [24:0] rr;
		h  = g ^ (g >> 16);
		x  = {1'b0, h[23:0], 16'd0} + 41'h7FFFFF;
		q0 = x[40:24];
		rr = {1'b0, x[23:0]} + 25'(q0);
		return (rr >= 25'hFFFFFF) ? q0 + 17'd1 : q0;
	endfunction

	function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] lo,
		input logic [VAL_W-1:0] hi, input logic [VAL_W-1:0] w);
		logic [2*VAL_W:0] s;
		s = (2*VAL_W+1)'(lo) * (2*VAL_W+1)'(VAL_ONE - w)
			+ (2*VAL_W+1)'(hi) * (2*VAL_W+1)'(w) + (2*VAL_W+1)'(HALF);
		return VAL_W'(s >> FRAC);
	endfunction

	logic [PER_W-1:0] per;
	logic [1:0][PU_W-1:0]   pu;
	logic [1:0][CELL_W-1:0] ca, cb;
	logic [1:0][CELL_W:0]   cinc;
	logic [1:0][FRAC-1:0]   tf;
	logic [3:0][31:0]       term_c, hmix_c;

	logic [6:0] v_q;
	logic [3:0][31:0]      term_s1, h_s2, g_s3;
	logic [1:0][FRAC-1:0]  t_s1, t_s2, t_s3, t_s4;
	logic [1:0][31:0]      tt_s1;
	logic [1:0][R_W-1:0]   r_s2, r_s3, r_s4;
	logic [3:0][VAL_W-1:0] c_s4, c_s5;
	logic [1:0][VAL_W-1:0] f_s5, ab_s6;
	logic [VAL_W-1:0]      fy_s6, n_s7;

	always_comb begin
		per   = PER_W'(base) << OCT;
		pu[0] = PU_W'(ub) << OCT;
		pu[1] = PU_W'(vb) << OCT;
		for (int a = 0; a < 2; a++) begin
			ca[a]   = pu[a][PU_W-1:FRAC];
			tf[a]   = pu[a][FRAC-1:0];
			cinc[a] = (CELL_W+1)'(ca[a]) + (CELL_W+1)'(1);
			// last cell wraps to cell zero
			cb[a]   = (cinc[a] == per) ? '0 : cinc[a][CELL_W-1:0];
		end
		term_c[0] = 32'(ca[0]) * HASH_X;
		term_c[1] = 32'(cb[0]) * HASH_X;
		term_c[2] = 32'(ca[1]) * HASH_Y;
		term_c[3] = 32'(cb[1]) * HASH_Y;
		// corners: 0 = (xa,ya), 1 = (xb,ya), 2 = (xa,yb), 3 = (xb,yb)
		for (int k = 0; k < 4; k++) begin
			hmix_c[k] = term_s1[k & 1] + term_s1[2 + (k >> 1)] + seed_term;
			hmix_c[k] = hmix_c[k] ^ (hmix_c[k] >> 13);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ctl.en) begin
			v_q <= {v_q[5:0], ctl.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			term_s1 <= term_c;
			for (int a = 0; a < 2; a++) begin
				t_s1[a]  <= tf[a];
				tt_s1[a] <= 32'(tf[a]) * 32'(tf[a]);
				t_s2[a]  <= t_s1[a];
				r_s2[a]  <= fade_head(tt_s1[a], t_s1[a]);
				t_s3[a]  <= t_s2[a];
				r_s3[a]  <= mul_rnd(t_s2[a], r_s2[a]);
				t_s4[a]  <= t_s3[a];
				r_s4[a]  <= mul_rnd(t_s3[a], r_s3[a]);
				f_s5[a]  <= VAL_W'(mul_rnd(t_s4[a], r_s4[a]));
			end
			h_s2 <= hmix_c;
			for (int k = 0; k < 4; k++) begin
				g_s3[k] <= h_s2[k] * HASH_M;
				c_s4[k] <= corner(g_s3[k]);
			end
			c_s5     <= c_s4;
			ab_s6[0] <= blend(c_s5[0], c_s5[1], f_s5[0]);
			ab_s6[1] <= blend(c_s5[2], c_s5[3], f_s5[0]);
			fy_s6    <= f_s5[1];
			n_s7     <= blend(ab_s6[0], ab_s6[1], fy_s6);
		end
	end

	assign n   = n_s7;
	assign vld = v_q[6];

endmodule

// ===== src/tvn_div.sv =====
// ----------------------------------------------------------------------------
// tvn_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tvn_div #(
	parameter int N_W = 38,
	parameter int D_W = 21,
	parameter int Q_W = 17
) (
	input  logic clk,
	input  logic arst_n,
	input  tvn_pkg::ctl_t   ctl,
	input  logic [N_W-1:0]  num,
	input  logic [D_W-1:0]  den,
	output logic [Q_W-1:0]  quo,
	output logic            vld
);
	import tvn_pkg::*;

	localparam int CW = (N_W > D_W + Q_W - 1) ? N_W : D_W + Q_W - 1;

	logic [Q_W-1:0][CW-1:0]  rem_n, rem_s;
	logic [Q_W-1:0][Q_W-1:0] q_n, q_s;
	logic [Q_W-1:0]          v_s;
	logic [CW-1:0] src, sh;
	logic [Q_W-1:0] qin;

	always_comb begin
		src = '0;
		qin = '0;
		sh  = '0;
		for (int j = 0; j < Q_W; j++) begin
			if (j == 0) begin
				src = CW'(num);
				qin = '0;
			end else begin
				src = rem_s[j-1];
				qin = q_s[j-1];
			end
			sh = CW'(den) << (Q_W - 1 - j);
			q_n[j] = qin;
			if (src >= sh) begin
				rem_n[j] = src - sh;
				q_n[j][Q_W-1-j] = 1'b1;
			end else begin
				rem_n[j] = src;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (ctl.en) begin
			v_s <= {v_s[Q_W-2:0], ctl.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rem_s <= rem_n;
			q_s   <= q_n;
		end
	end

	assign quo = q_s[Q_W-1];
	assign vld = v_s[Q_W-1];

endmodule

// ===== src/tileable_value_noise_fbm_unit.sv =====
// ----------------------------------------------------------------------------
// tileable_value_noise_fbm_unit
// Seamless fractal value noise over a tile: octave lanes in parallel, weighted
// sum, pipelined normalising divider, output register with skid slot.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------
//  input     | in_valid / in_ready  | coord_u, coord_v (Q0.16)
//  output    | out_valid / out_ready| noise_value (Q0.16, saturated)
//  config    | cfg_we               | cfg_index, cfg_data
//
//  One beat per cycle unless a stall or the config settle holds in_ready low;
//  28 register stages in all (1 scale stage, 7 lane stages, 2 sum stages,
//  17 divider stages, out reg).
//  After reset and after every config write in_ready stays low while the
//  amplitude chain and seed terms settle.
//  A stall parks one result in the skid slot; the whole pipe then freezes
//  and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tileable_value_noise_fbm_unit #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [tvn_pkg::COORD_W-1:0] coord_u,
	input  logic [tvn_pkg::COORD_W-1:0] coord_v,
	output logic out_valid,
	input  logic out_ready,
	output logic [tvn_pkg::OUT_W-1:0] noise_value,
	input  logic cfg_we,
	input  logic [tvn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvn_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tvn_pkg::*;
	`include "tileable_value_noise_fbm_unit_defines.svh"

	localparam int NORM_W   = AMP_W + $clog2(MAX_OCTAVES);
	localparam int PROD_W   = 33;                       // n * amp <= 2^32
	localparam int NUM_W    = 35 + $clog2(MAX_OCTAVES); // 2*sum + total
	localparam int DEN_W    = NORM_W + 1;
	localparam int Q_W      = 17;
	localparam int SETTLE   = MAX_OCTAVES + 1;
	localparam int SETTLE_W = $clog2(SETTLE + 1);
	localparam logic [Q_W-1:0] Q_MAX = 17'h10000;

	// configuration registers
	logic [OCT_W-1:0]  octaves_q;
	logic [BASE_W-1:0] base_q;
	logic [PERS_W-1:0] pers_q;
	logic [SEED_W-1:0] seed_q;
	logic [SETTLE_W-1:0] settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q <= 4'd4;
			base_q    <= 7'd4;
			pers_q    <= 17'd32768;
			seed_q    <= '0;
			settle_q  <= SETTLE_W'(SETTLE);
		end else if (cfg_we) begin
			settle_q <= SETTLE_W'(SETTLE);
			case (cfg_index)
				REG_OCTAVE_COUNT: octaves_q <= cfg_data[OCT_W-1:0];
				REG_BASE_PERIOD:  base_q    <= cfg_data[BASE_W-1:0];
				REG_PERSISTENCE:  pers_q    <= cfg_data[PERS_W-1:0];
				REG_NOISE_SEED:   seed_q    <= cfg_data[SEED_W-1:0];
				default: ;
			endcase
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	// derived coefficients
	logic [MAX_OCTAVES-1:0][AMP_W-1:0]  amp;
	logic [MAX_OCTAVES-1:0]             act;
	logic [NORM_W-1:0]                  norm;
	logic [MAX_OCTAVES-1:0][SEED_W-1:0] seed_term;

	tvn_coef #(.MAX_OCTAVES(MAX_OCTAVES)) u_coef (
		.clk        (clk),
		.octaves    (octaves_q),
		.persistence(pers_q),
		.seed       (seed_q),
		.amp        (amp),
		.act        (act),
		.norm       (norm),
		.seed_term  (seed_term)
	);

	// pipe control: whole pipe advances unless the skid slot is holding
	logic skid_v_q;
	logic [OUT_W-1:0] skid_d_q;
	logic en;
	ctl_t lane_ctl, div_ctl;

	assign en       = !skid_v_q;
	assign in_ready = en && (settle_q == '0);

	// stage 1: coordinate times base period
	logic [BASE_W-1:0] base_eff;
	logic v_s1;
	logic [UB_W-1:0] ub_s1, vb_s1;

	always_comb begin
		if (base_q == '0) begin
			base_eff = BASE_W'(1);
		end else if (base_q > BASE_W'(MAX_BASE)) begin
			base_eff = BASE_W'(MAX_BASE);
		end else begin
			base_eff = base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ub_s1 <= UB_W'(coord_u) * UB_W'(base_eff);
			vb_s1 <= UB_W'(coord_v) * UB_W'(base_eff);
		end
	end

	// octave lanes
	logic [MAX_OCTAVES-1:0][VAL_W-1:0] lane_n;
	logic [MAX_OCTAVES-1:0]            lane_vld;

	assign lane_ctl = '{en: en, vld: v_s1};

	for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
		tvn_octave #(.OCT(g)) u_oct (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.ub       (ub_s1),
			.vb       (vb_s1),
			.base     (base_eff),
			.seed_term(seed_term[g]),
			.n        (lane_n[g]),
			.vld      (lane_vld[g])
		);
	end

	// weighting and sum; rounding half of the total folded into the dividend
	logic v_s9, v_s10;
	logic [MAX_OCTAVES-1:0][PROD_W-1:0] prod_s9;
	logic [NUM_W-1:0] num_c, num_s10;

	always_comb begin
		num_c = NUM_W'(norm);
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			num_c = num_c + (NUM_W'(prod_s9[i]) << 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s9  <= &lane_vld;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAX_OCTAVES; i++) begin
				prod_s9[i] <= act[i] ? PROD_W'(34'(lane_n[i]) * 34'(amp[i])) : '0;
			end
			num_s10 <= num_c;
		end
	end

	// normalise: (2*sum + total) / (2*total)
	logic [Q_W-1:0] div_q;
	logic div_vld;
	logic [OUT_W-1:0] res;

	assign div_ctl = '{en: en, vld: v_s10};

	tvn_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(Q_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (div_ctl),
		.num   (num_s10),
		.den   ({norm, 1'b0}),
		.quo   (div_q),
		.vld   (div_vld)
	);

	// only a full-scale average can reach 1.0, which saturates
	assign res = div_q[Q_W-1] ? {OUT_W{1'b1}} : div_q[OUT_W-1:0];

	// output register plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (out_ready || !out_valid) begin
			if (skid_v_q) begin
				out_valid <= 1'b1;
				skid_v_q  <= 1'b0;
			end else begin
				out_valid <= div_vld;
			end
		end else if (div_vld) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid) begin
			noise_value <= skid_v_q ? skid_d_q : res;
		end else if (div_vld && en) begin
			skid_d_q <= res;
		end
	end

	`TVN_ASSERT_IMP(a_skid_needs_out, skid_v_q, out_valid)
	`TVN_ASSERT_IMP(a_skid_on_stall, $rose(skid_v_q), $past(out_valid && !out_ready))
	`TVN_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !in_ready)
	`TVN_ASSERT_IMP(a_quot_range, div_vld, div_q <= Q_MAX)

endmodule

// ===== tb/tileable_value_noise_fbm_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for tileable_value_noise_fbm_unit
// Drives coordinate beats through several register settings and idling
// phases. Each accepted beat is scored by a fixed-point fBm value-noise
// predictor, and the result stream is checked in order against it.
// ----------------------------------------------------------------------------
module tileable_value_noise_fbm_unit_tb;

	import tvn_pkg::*;

	typedef longint unsigned u64;

	typedef struct {
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
	} coord_t;

	localparam int LATENCY_WAIT = 60;   // beyond the pipe plus config settle
	localparam int STALL_LIMIT  = 3000; // cycles with no beat on either side
	localparam int HOLD_CYCLES  = 400;  // long receiver hold-off for back-pressure

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_W-1:0] coord_u = '0;
	logic [COORD_W-1:0] coord_v = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [OUT_W-1:0] noise_value;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_OCTAVE_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register shadows, raw as written
	logic [OCT_W-1:0]  sh_octaves;
	logic [BASE_W-1:0] sh_base;
	logic [PERS_W-1:0] sh_pers;
	logic [SEED_W-1:0] sh_seed;

	coord_t pending_coords[$];
	logic [OUT_W-1:0] expected_noise[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	tileable_value_noise_fbm_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_u(coord_u), .coord_v(coord_v),
		.out_valid(out_valid), .out_ready(out_ready),
		.noise_value(noise_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	// hashed lattice corner, scaled to 0..1.0 in Q.16
	function automatic u64 lattice_corner(logic [31:0] x, logic [31:0] y, logic [31:0] seed);
		logic [31:0] h;
		u64 m;
		h = x * HASH_X + y * HASH_Y + seed * SEED_MUL;
		h = (h ^ (h >> 13)) * HASH_M;
		h = h ^ (h >> 16);
		m = u64'(h[23:0]);
		return ((m << FRAC) + 64'h7FFFFF) / 64'hFFFFFF;
	endfunction

	// 6t^5 - 15t^4 + 10t^3 with a rounding step after each multiply
	function automatic u64 quintic_fade(u64 t);
		u64 q;
		u64 r;
		q = 6 * t * t + 10 * (u64'(1) << (2 * FRAC)) - 15 * t * (u64'(1) << FRAC);
		r = (q + HALF) >> FRAC;
		r = (t * r + HALF) >> FRAC;
		r = (t * r + HALF) >> FRAC;
		r = (t * r + HALF) >> FRAC;
		return r;
	endfunction

	function automatic u64 mix_q16(u64 lo, u64 hi, u64 w);
		return (lo * ((u64'(1) << FRAC) - w) + hi * w + HALF) >> FRAC;
	endfunction

	function automatic u64 octave_sample(u64 u, u64 v, u64 period, logic [31:0] seed);
		u64 pu, pv, xa, ya, xb, yb, fx, fy, top, bot;
		pu = u * period;
		pv = v * period;
		xa = (pu >> 16) % period;
		ya = (pv >> 16) % period;
		xb = (xa + 1) % period;   // last cell wraps to zero so tiles join
		yb = (ya + 1) % period;
		fx = quintic_fade(pu & 64'hFFFF);
		fy = quintic_fade(pv & 64'hFFFF);
		top = mix_q16(lattice_corner(32'(xa), 32'(ya), seed),
		              lattice_corner(32'(xb), 32'(ya), seed), fx);
		bot = mix_q16(lattice_corner(32'(xa), 32'(yb), seed),
		              lattice_corner(32'(xb), 32'(yb), seed), fx);
		return mix_q16(top, bot, fy);
	endfunction

	function automatic logic [OUT_W-1:0] fbm_noise_value(logic [COORD_W-1:0] u,
	                                                     logic [COORD_W-1:0] v);
		u64 octs, base, pers, amp, acc, norm, den, res;
		logic [31:0] seed;
		octs = u64'(sh_octaves);
		base = u64'(sh_base);
		pers = u64'(sh_pers);
		amp = 65536;
		acc = 0;
		norm = 0;
		// out-of-range registers saturate
		if (octs < 1) octs = 1;
		if (octs > 8) octs = 8;
		if (base < 1) base = 1;
		if (base > MAX_BASE) base = MAX_BASE;
		if (pers > 65536) pers = 65536;
		for (int i = 0; i < octs; i++) begin
			seed = sh_seed + 32'(i) * SEED_STEP;
			acc += octave_sample(u64'(u), u64'(v), base << i, seed) * amp;
			norm += amp;
			amp = (amp * pers + 32768) >> 16;
		end
		den = norm << FRAC;
		res = ((acc << 16) + (den >> 1)) / den;
		if (res > 65535) res = 65535;
		return res[OUT_W-1:0];
	endfunction

	// ---------------------------------------------------------------- driver
	// valid holds with its payload until taken; prediction made at acceptance
	always @(posedge clk) begin
		coord_t c;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_noise.push_back(fbm_noise_value(coord_u, coord_v));
			end
			if (!in_valid || in_ready) begin
				if (pending_coords.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					c = pending_coords.pop_front();
					in_valid <= 1'b1;
					coord_u <= c.u;
					coord_v <= c.v;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_noise.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected beat noise_value=%0d", $realtime, noise_value);
				end else begin
					want = expected_noise.pop_front();
					if (noise_value !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] noise_value mismatch: expected %0d, got %0d",
							         $realtime, want, noise_value);
					end
				end
			end
			// long hold-off: the pipe fills and in_ready must drop
			if (hold_request && hold_left == 0) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_OCTAVE_COUNT: sh_octaves = val[OCT_W-1:0];
			REG_BASE_PERIOD:  sh_base = val[BASE_W-1:0];
			REG_PERSISTENCE:  sh_pers = val[PERS_W-1:0];
			REG_NOISE_SEED:   sh_seed = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [CFG_DATA_W-1:0] octs, logic [CFG_DATA_W-1:0] base,
	                        logic [CFG_DATA_W-1:0] pers, logic [CFG_DATA_W-1:0] seed);
		write_reg(REG_OCTAVE_COUNT, octs);
		write_reg(REG_BASE_PERIOD, base);
		write_reg(REG_PERSISTENCE, pers);
		write_reg(REG_NOISE_SEED, seed);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_coord(int u, int v);
		coord_t c;
		c.u = u[COORD_W-1:0];
		c.v = v[COORD_W-1:0];
		pending_coords.push_back(c);
	endtask

	// mostly uniform, some pinned to the ends and cell edges
	function automatic int pick_coord();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(0, 63) << 10;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) queue_coord(pick_coord(), pick_coord());
	endtask

	// wait for everything to drain, then let the pipe fall idle
	task automatic drain();
		wait (pending_coords.size() == 0 && !in_valid && expected_noise.size() == 0);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		sh_octaves = 4;
		sh_base = 4;
		sh_pers = 32768;
		sh_seed = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners at reset settings
		queue_coord(0, 0);
		queue_coord(65535, 65535);
		queue_coord(65535, 0);
		queue_coord(0, 65535);
		queue_coord(32768, 32768);
		queue_coord(16384, 49152);   // exact cell boundaries at period 4
		queue_coord(49151, 16383);
		queue_coord(21845, 43690);   // alternating bit patterns
		queue_coord(43690, 21845);
		queue_coord(1, 65534);
		drain();

		// zero octaves, zero period, zero persistence
		set_regs(0, 0, 0, 32'h1234_5678);
		queue_coord(0, 0);
		queue_coord(65535, 65535);
		queue_coord(12345, 54321);
		drain();

		// everything above range: saturates to 8 octaves, 64 cells, weight 1.0
		set_regs(15, 127, 131071, 32'hFFFF_FFFF);
		queue_coord(0, 0);
		queue_coord(65535, 65535);
		queue_coord(65535, 1024);
		queue_coord(1023, 64511);
		drain();

		// widest legal settings, sender idles
		set_regs(8, 64, 65536, 32'hFFFF_FFFF);
		send_idle_pct = 73;
		queue_random(300);
		drain();

		// single octave on a single cell, receiver stalls
		set_regs(1, 1, 0, 0);
		send_idle_pct = 0;
		recv_stall_pct = 73;
		queue_random(300);
		drain();

		// both sides idle
		set_regs(4, 4, 32768, $urandom());
		send_idle_pct = 35;
		recv_stall_pct = 35;
		queue_random(300);
		drain();

		// full back-pressure: receiver holds off while the sender keeps offering
		set_regs($urandom_range(1, 8), $urandom_range(1, 64), $urandom_range(0, 65536),
		         $urandom());
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(300);
		hold_request = 1;
		drain();

		// random settings, random idling, raw register bits now and then
		for (int p = 0; p < 4; p++) begin
			if (p == 3)
				set_regs($urandom(), $urandom(), $urandom(), $urandom());
			else
				set_regs($urandom_range(1, 8), $urandom_range(1, 64),
				         $urandom_range(0, 65536), $urandom());
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			queue_random(200);
			drain();
		end

		if (mismatches == 0 && expected_noise.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/tvn_pkg.sv
src/tvn_coef.sv
src/tvn_octave.sv
src/tvn_div.sv
src/tileable_value_noise_fbm_unit.sv
tb/tileable_value_noise_fbm_unit_tb.sv
